// ----- rtl/tsbc_pkg.sv -----
// ---------------------------------------------------------------------------
// tsbc_pkg: shared types, constants and functions
// Register codes, reset values and the round functions of the toy SPN
// byte cipher used in counter mode.
// ---------------------------------------------------------------------------
package tsbc_pkg;

  localparam int unsigned NumRounds = 3;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 64;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_KEY  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_SBOX = cfg_idx_t'(1);
  localparam cfg_idx_t REG_PERM = cfg_idx_t'(2);
  localparam cfg_idx_t REG_IV   = cfg_idx_t'(3);

  // reset values: zero key, identity S-box and permutation, zero IV
  localparam logic [31:0] KeyReset  = 32'h0000_0000;
  localparam logic [63:0] SboxReset = 64'hFEDC_BA98_7654_3210;
  localparam logic [23:0] PermReset = 24'hFA_C688;
  localparam logic [7:0]  IvReset   = 8'h00;

  // configuration seen by the datapath
  typedef struct packed {
    logic [31:0] key;
    logic [63:0] sbox;
    logic [23:0] perm;
    logic [7:0]  iv;
  } cfg_t;

  // 4-bit substitution on both nibbles
  function automatic logic [7:0] sub_byte(input logic [7:0] x, input logic [63:0] sbox);
    logic [3:0] hi;
    logic [3:0] lo;
    hi = sbox[{x[7:4], 2'b00} +: 4];
    lo = sbox[{x[3:0], 2'b00} +: 4];
    return {hi, lo};
  endfunction

  // bit permutation: entry i moves bit 7-i to bit 7-entry; collisions OR
  function automatic logic [7:0] perm_byte(input logic [7:0] x, input logic [23:0] perm);
    logic [7:0] y;
    logic [2:0] tgt;
    y = '0;
    for (int i = 0; i < 8; i++) begin
      tgt = perm[3*i +: 3];
      y[3'd7 - tgt] = y[3'd7 - tgt] | x[7-i];
    end
    return y;
  endfunction

endpackage

// ----- rtl/tsbc_in_if.sv -----
// ---------------------------------------------------------------------------
// tsbc_in_if: plaintext item channel
// Valid/ready channel carrying one plaintext byte and its message start mark.
// ---------------------------------------------------------------------------
interface tsbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       first;

  modport source (output valid, output plain_byte, output first, input ready);
  modport sink   (input valid, input plain_byte, input first, output ready);
endinterface

// ----- rtl/tsbc_out_if.sv -----
// ---------------------------------------------------------------------------
// tsbc_out_if: result item channel
// Valid/ready channel carrying an IV header byte or a ciphertext byte.
// ---------------------------------------------------------------------------
interface tsbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_iv;
  logic       last;

  modport source (output valid, output out_byte, output is_iv, output last, input ready);
  modport sink   (input valid, input out_byte, input is_iv, input last, output ready);
endinterface

// ----- rtl/tsbc_cfg_if.sv -----
// ---------------------------------------------------------------------------
// tsbc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface tsbc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tsbc_pkg::CfgIdxW-1:0]  index;
  logic [tsbc_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/tsbc_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// tsbc_cfg_regs: configuration register file
// Holds key, S-box table, bit permutation and IV; writes always accepted,
// unknown indexes dropped, excess data bits masked.
// ---------------------------------------------------------------------------
module tsbc_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  tsbc_cfg_if.sink       cfg,
  output tsbc_pkg::cfg_t regs
);
  import tsbc_pkg::*;

  assign cfg.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.key  <= KeyReset;
      regs.sbox <= SboxReset;
      regs.perm <= PermReset;
      regs.iv   <= IvReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_KEY:  regs.key  <= cfg.data[31:0];
        REG_SBOX: regs.sbox <= cfg.data;
        REG_PERM: regs.perm <= cfg.data[23:0];
        REG_IV:   regs.iv   <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/tsbc_cipher.sv -----
// ---------------------------------------------------------------------------
// tsbc_cipher: keystream block function
// Three rounds of key XOR, nibble S-box and bit permutation, then a final
// key XOR; pure combinational logic between the pipeline registers.
// ---------------------------------------------------------------------------
module tsbc_cipher (
  input  tsbc_pkg::cfg_t regs,
  input  logic [7:0]     ctr,
  output logic [7:0]     keystream
);
  import tsbc_pkg::*;

  logic [7:0] st [NumRounds+1];

  assign st[0] = ctr;

  // one round per generate slice, key byte 0 (MSB) first
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    logic [7:0] mixed;
    assign mixed     = st[r] ^ regs.key[31-8*r -: 8];
    assign st[r+1]   = perm_byte(sub_byte(mixed, regs.sbox), regs.perm);
  end

  assign keystream = st[NumRounds] ^ regs.key[7:0];

endmodule

// ----- rtl/toy_spn_byte_cipher_ctr.sv -----
// ---------------------------------------------------------------------------
// toy_spn_byte_cipher_ctr: counter-mode byte stream cipher
// Path: input accept into the input register, then the result register after
//   the three-round cipher logic.
// Throughput: one item per cycle unless the output stalls; an item marked first
//   gives two results and holds the result register until both are taken.
// Reset: rst (sync) clears counter, pipeline valids and restores config.
// ---------------------------------------------------------------------------
module toy_spn_byte_cipher_ctr (
  input  logic      clk,
  input  logic      rst,
  tsbc_cfg_if.sink  cfg,
  tsbc_in_if.sink   plain_stream,
  tsbc_out_if.source cipher_stream
);
  import tsbc_pkg::*;

  cfg_t       regs;
  logic [7:0] counter;
  logic [7:0] ctr_use;
  logic       in_acc;
  logic       o_free;

  // input register
  logic       s1_valid;
  logic [7:0] s1_plain;
  logic       s1_first;
  logic [7:0] s1_ctr;
  logic [7:0] keystream;

  // result register
  logic       o_valid;
  logic       o_iv_pend;
  logic [7:0] o_iv;
  logic [7:0] o_cipher;

  tsbc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  tsbc_cipher u_cipher (
    .regs      (regs),
    .ctr       (s1_ctr),
    .keystream (keystream)
  );

  // handshake
  assign o_free             = !o_valid || (cipher_stream.ready && !o_iv_pend);
  assign plain_stream.ready = !s1_valid || o_free;
  assign in_acc             = plain_stream.valid && plain_stream.ready;
  assign ctr_use            = plain_stream.first ? regs.iv : counter;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      counter   <= '0;
      s1_valid  <= 1'b0;
      o_valid   <= 1'b0;
      o_iv_pend <= 1'b0;
    end else begin
      if (in_acc) begin
        counter <= ctr_use + 8'd1;
      end
      if (plain_stream.ready) begin
        s1_valid <= plain_stream.valid;
      end
      if (o_free) begin
        o_valid   <= s1_valid;
        o_iv_pend <= s1_valid && s1_first;
      end else if (cipher_stream.ready) begin
        // IV header taken, ciphertext follows
        o_iv_pend <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_plain <= plain_stream.plain_byte;
      s1_first <= plain_stream.first;
      s1_ctr   <= ctr_use;
    end
    if (o_free && s1_valid) begin
      o_iv     <= s1_ctr;
      o_cipher <= s1_plain ^ keystream;
    end
  end

  assign cipher_stream.valid    = o_valid;
  assign cipher_stream.out_byte = o_iv_pend ? o_iv : o_cipher;
  assign cipher_stream.is_iv    = o_iv_pend;
  assign cipher_stream.last     = !o_iv_pend;

  // checks
  a_iv_then_cipher: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_iv_pend && cipher_stream.ready) |=> (o_valid && !o_iv_pend))
    else $error("IV header not followed by its ciphertext");

  a_ctr_step: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !plain_stream.first) |=> (counter == $past(counter) + 8'd1))
    else $error("counter did not advance");

  a_ctr_reload: assert property (@(posedge clk) disable iff (rst)
    (in_acc && plain_stream.first) |=> (counter == $past(regs.iv) + 8'd1))
    else $error("counter did not reload from IV");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !o_free) |=> s1_valid)
    else $error("input register dropped a stalled item");

endmodule
